FILE: rtl/mi3_pkg.sv
`timescale 1ns / 1ps
package mi3_pkg;

   // fixed-point format and derived widths
   localparam int FRAC_BITS = 16;
   localparam int SH        = 2 * FRAC_BITS;
   localparam int NUM_W     = 64 + SH;
   localparam int REM0_W    = NUM_W - 32;
   localparam int DEN_W     = 99;
   localparam int DET_W     = 100;
   localparam int DIV_STEPS = 32;
   // cofactor 2 + determinant 3 + divider 1 + steps + output 1
   localparam int LAT       = 2 + 3 + 1 + DIV_STEPS + 1;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef logic signed [31:0] fix_type;
   typedef logic signed [63:0] prod_type;
   typedef logic signed [64:0] cof_type;
   typedef logic [63:0]        mag_type;
   typedef logic [DEN_W-1:0]   den_type;
   typedef logic signed [DET_W-1:0] det_type;

   typedef struct packed {
      fix_type a00; fix_type a01; fix_type a02;
      fix_type a10; fix_type a11; fix_type a12;
      fix_type a20; fix_type a21; fix_type a22;
   } mtx_in_type;

   typedef struct packed {
      fix_type b00; fix_type b01; fix_type b02;
      fix_type b10; fix_type b11; fix_type b12;
      fix_type b20; fix_type b21; fix_type b22;
      logic    singular;
   } mtx_out_type;

   // determinant result handed to the divider lanes
   typedef struct packed {
      den_type den;
      logic    neg;
      logic    zero;
   } det_info_type;

endpackage

FILE: rtl/mi3_cofactor.sv
`timescale 1ns / 1ps
module mi3_cofactor (
   input  logic               clock,
   input  mi3_pkg::fix_type   m_in [3][3],
   output mi3_pkg::fix_type   row0_out [3],
   output mi3_pkg::cof_type   cof_out [3][3]
);

   mi3_pkg::prod_type pa_ff [3][3];
   mi3_pkg::prod_type pb_ff [3][3];
   mi3_pkg::fix_type  r0_ff [3];
   mi3_pkg::prod_type pa_in [3][3];
   mi3_pkg::prod_type pb_in [3][3];
   mi3_pkg::cof_type  cof_ff [3][3];
   mi3_pkg::cof_type  cof_in [3][3];
   mi3_pkg::fix_type  r0b_ff [3];

   // minor products, one pair per entry
   always_comb begin
      int r1, r2, c1, c2;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            c1 = (c == 0) ? 1 : 0;
            c2 = (c == 2) ? 1 : 2;
            pa_in[r][c] = m_in[r1][c1] * m_in[r2][c2];
            pb_in[r][c] = m_in[r1][c2] * m_in[r2][c1];
         end
      end
   end

   // minor difference with checkerboard sign
   always_comb begin
      mi3_pkg::cof_type d;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            d = 65'(pa_ff[r][c]) - 65'(pb_ff[r][c]);
            cof_in[r][c] = (((r + c) % 2) != 0) ? -d : d;
         end
      end
   end

   always_ff @(posedge clock) begin
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      r0_ff  <= m_in[0];
      cof_ff <= cof_in;
      r0b_ff <= r0_ff;
   end

   assign cof_out  = cof_ff;
   assign row0_out = r0b_ff;

endmodule

FILE: rtl/mi3_det.sv
`timescale 1ns / 1ps
module mi3_det (
   input  logic                    clock,
   input  mi3_pkg::fix_type        row0_in [3],
   input  mi3_pkg::cof_type        cof_in [3][3],
   output mi3_pkg::det_info_type   det_out,
   output mi3_pkg::mag_type        cmag_out [3][3],
   output logic                    cneg_out [3][3]
);

   logic signed [65:0] plo_ff [3];
   logic signed [63:0] phi_ff [3];
   logic signed [65:0] plo_in [3];
   logic signed [63:0] phi_in [3];
   mi3_pkg::cof_type   cofc_ff [3][3];
   mi3_pkg::cof_type   cofd_ff [3][3];
   mi3_pkg::det_type   det_ff;
   mi3_pkg::det_type   det_in;
   mi3_pkg::det_info_type info_ff;
   mi3_pkg::det_info_type info_in;
   mi3_pkg::mag_type   cmag_ff [3][3];
   mi3_pkg::mag_type   cmag_in [3][3];
   logic               cneg_ff [3][3];

   // split each row-0 65-bit cofactor into a signed 32-bit high and unsigned 33-bit low part
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         plo_in[c] = row0_in[c] * $signed({1'b0, cof_in[0][c][32:0]});
         phi_in[c] = row0_in[c] * $signed(cof_in[0][c][64:33]);
      end
   end

   // determinant sum
   always_comb begin
      det_in = '0;
      for (int c = 0; c < 3; c++) begin
         det_in = det_in + (mi3_pkg::DET_W'(phi_ff[c]) <<< 33)
                         + mi3_pkg::DET_W'(plo_ff[c]);
      end
   end

   // sign, magnitude and zero test
   always_comb begin
      mi3_pkg::det_type dm;
      dm = det_ff[mi3_pkg::DET_W-1] ? -det_ff : det_ff;
      info_in.den  = dm[mi3_pkg::DEN_W-1:0];
      info_in.neg  = det_ff[mi3_pkg::DET_W-1];
      info_in.zero = (det_ff == '0);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            cmag_in[r][c] = cofd_ff[r][c][64] ? 64'(-cofd_ff[r][c])
                                              : cofd_ff[r][c][63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      cofc_ff <= cof_in;
      det_ff  <= det_in;
      cofd_ff <= cofc_ff;
      info_ff <= info_in;
      cmag_ff <= cmag_in;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            cneg_ff[r][c] <= cofd_ff[r][c][64];
         end
      end
   end

   assign det_out  = info_ff;
   assign cmag_out = cmag_ff;
   assign cneg_out = cneg_ff;

endmodule

FILE: rtl/mi3_div_lane.sv
`timescale 1ns / 1ps
module mi3_div_lane (
   input  logic              clock,
   input  mi3_pkg::mag_type  mag_in,
   input  logic              neg_in,
   input  mi3_pkg::den_type  den_in,
   output mi3_pkg::fix_type  q_out
);

   localparam int N = mi3_pkg::DIV_STEPS;
   localparam int DW = mi3_pkg::DEN_W;

   logic [mi3_pkg::NUM_W-1:0] num_wide;
   mi3_pkg::den_type rem0;
   mi3_pkg::den_type rem_ff [N+1];
   mi3_pkg::den_type rem_in [N+1];
   mi3_pkg::den_type den_ff [N+1];
   logic [31:0]      lo_ff  [N+1];
   logic [31:0]      q_ff   [N+1];
   logic [31:0]      q_in   [N+1];
   logic             ovf_ff [N+1];
   logic             neg_ff [N+1];

   // scaled numerator; high part seeds the remainder
   assign num_wide = {mag_in, {mi3_pkg::SH{1'b0}}};
   assign rem0 = DW'(num_wide[mi3_pkg::NUM_W-1:32]);

   // one restoring step per stage
   always_comb begin
      logic [DW:0] t;
      logic [DW:0] diff;
      rem_in[0] = rem0;
      q_in[0]   = '0;
      for (int k = 1; k <= N; k++) begin
         t    = {rem_ff[k-1], lo_ff[k-1][31]};
         diff = t - {1'b0, den_ff[k-1]};
         if (!diff[DW]) begin
            rem_in[k] = diff[DW-1:0];
            q_in[k]   = {q_ff[k-1][30:0], 1'b1};
         end else begin
            rem_in[k] = t[DW-1:0];
            q_in[k]   = {q_ff[k-1][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in[0];
      q_ff[0]   <= q_in[0];
      lo_ff[0]  <= num_wide[31:0];
      den_ff[0] <= den_in;
      ovf_ff[0] <= (rem0 >= den_in);
      neg_ff[0] <= neg_in;
      for (int k = 1; k <= N; k++) begin
         rem_ff[k] <= rem_in[k];
         q_ff[k]   <= q_in[k];
         lo_ff[k]  <= {lo_ff[k-1][30:0], 1'b0};
         den_ff[k] <= den_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   // sign and saturation
   always_comb begin
      if (ovf_ff[N] || q_ff[N][31]) begin
         q_out = neg_ff[N] ? mi3_pkg::SAT_MIN : mi3_pkg::SAT_MAX;
      end else begin
         q_out = neg_ff[N] ? -q_ff[N] : q_ff[N];
      end
   end

endmodule

FILE: rtl/matrix3x3_inverse_top.sv
`timescale 1ns / 1ps
// channel   ports                         direction
// request   start, busy, req_data         in  (transfer when start && !busy)
// response  rsp_valid, rsp_data           out (one cycle strobe)
//
// one matrix enters every cycle; busy is always low
// a matrix passes through the cofactor, determinant, divider and output stages in that order
// the 32 quotient bits come from a 32-step restoring divider, one per entry
// reset clears only the valid chain; payload stages carry no reset
// the receiver cannot stall, so the pipeline never holds
module matrix3x3_inverse_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mi3_pkg::mtx_in_type   req_data,
   output logic                  rsp_valid,
   output mi3_pkg::mtx_out_type  rsp_data
);

   localparam int LAT = mi3_pkg::LAT;

   mi3_pkg::fix_type      m [3][3];
   mi3_pkg::fix_type      row0 [3];
   mi3_pkg::cof_type      cof [3][3];
   mi3_pkg::det_info_type det;
   mi3_pkg::mag_type      cmag [3][3];
   logic                  cneg [3][3];
   mi3_pkg::fix_type      q [3][3];
   logic [LAT-1:0]        vld_ff;
   logic [LAT-1:0]        vld_in;
   logic [mi3_pkg::DIV_STEPS:0] sing_ff;
   mi3_pkg::mtx_out_type  out_ff;
   mi3_pkg::mtx_out_type  out_in;

   assign busy = 1'b0;

   assign m[0][0] = req_data.a00; assign m[0][1] = req_data.a01;
   assign m[0][2] = req_data.a02; assign m[1][0] = req_data.a10;
   assign m[1][1] = req_data.a11; assign m[1][2] = req_data.a12;
   assign m[2][0] = req_data.a20; assign m[2][1] = req_data.a21;
   assign m[2][2] = req_data.a22;

   mi3_cofactor u_cof (
      .clock    (clock),
      .m_in     (m),
      .row0_out (row0),
      .cof_out  (cof)
   );

   mi3_det u_det (
      .clock    (clock),
      .row0_in  (row0),
      .cof_in   (cof),
      .det_out  (det),
      .cmag_out (cmag),
      .cneg_out (cneg)
   );

   // lanes read the cofactor transposed: b[r][c] = cof[c][r] / det
   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         mi3_div_lane u_lane (
            .clock  (clock),
            .mag_in (cmag[c][r]),
            .neg_in (cneg[c][r] ^ det.neg),
            .den_in (det.den),
            .q_out  (q[r][c])
         );
      end
   end

   // valid chain
   assign vld_in = {vld_ff[LAT-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // singular flag follows the divider stages
   always_ff @(posedge clock) begin
      sing_ff <= {sing_ff[mi3_pkg::DIV_STEPS-1:0], det.zero};
   end

   // output register
   always_comb begin
      if (sing_ff[mi3_pkg::DIV_STEPS]) begin
         out_in = '0;
         out_in.singular = 1'b1;
      end else begin
         out_in.b00 = q[0][0]; out_in.b01 = q[0][1]; out_in.b02 = q[0][2];
         out_in.b10 = q[1][0]; out_in.b11 = q[1][1]; out_in.b12 = q[1][2];
         out_in.b20 = q[2][0]; out_in.b21 = q[2][1]; out_in.b22 = q[2][2];
         out_in.singular = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = out_ff;

   // every accepted matrix comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(LAT) rsp_valid)
      else $error("transfer lost in pipeline");

   // a singular result carries all-zero entries; b00, b11, b22, b01, b12 and b20 are checked
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |->
         (rsp_data.b00 == '0 && rsp_data.b11 == '0 && rsp_data.b22 == '0 &&
          rsp_data.b01 == '0 && rsp_data.b12 == '0 && rsp_data.b20 == '0))
      else $error("singular result with nonzero entries");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response strobe after reset");

endmodule
